// File: rtl/uafu_pkg.sv
// Shared types and constants for the USB audio feature-unit volume responder.
`default_nettype none

package uafu_pkg;

  // Opcodes of an incoming item
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Class request codes
  localparam logic [7:0] RQ_SET_CUR = 8'h01;
  localparam logic [7:0] RQ_GET_CUR = 8'h81;
  localparam logic [7:0] RQ_GET_MIN = 8'h82;
  localparam logic [7:0] RQ_GET_MAX = 8'h83;
  localparam logic [7:0] RQ_GET_RES = 8'h84;

  // Feature controls and units
  localparam logic [7:0] SEL_MUTE = 8'd1;
  localparam logic [7:0] SEL_VOL  = 8'd2;
  localparam logic [7:0] ENT_SPK  = 8'h02;
  localparam logic [7:0] ENT_MIC  = 8'h05;

  // Configuration register indexes
  localparam logic [7:0] CFG_VOL_LOCK        = 8'd0;
  localparam logic [7:0] CFG_DEFAULT_PERCENT = 8'd1;
  localparam logic [7:0] DEFAULT_PERCENT_RESET = 8'd100;

  // Volume ranges in signed 1/256 dB
  localparam logic [15:0] SPK_VOL_MIN = 16'hB700;
  localparam logic [15:0] SPK_VOL_MAX = 16'hFF00;
  localparam logic [15:0] SPK_VOL_RES = 16'h0100;
  localparam logic [15:0] MIC_VOL_MIN = 16'hE8C0;
  localparam logic [15:0] MIC_VOL_MAX = 16'h1800;
  localparam logic [15:0] MIC_VOL_RES = 16'h00C0;
  localparam logic [15:0] MIC_VOL_RESET = 16'h3000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  request_code;
    logic [7:0]  control_selector;
    logic [7:0]  entity_id;
    logic [15:0] request_length;
    logic [15:0] payload;
  } uafu_req_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  reply_length;
    logic [15:0] reply_data;
    logic        level_valid;
    logic [6:0]  amp_level;
  } uafu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/uafu_amp.sv
// Amplifier level mapping from speaker mute and volume.
`default_nettype none

module uafu_amp
  import uafu_pkg::*;
(
  input  wire logic [7:0]  mute,
  input  wire logic [15:0] volume,
  output logic      [6:0]  level
);

  // Clamp bounds: -73 dB and -1 dB in 1/256 dB
  localparam logic signed [15:0] VOL_LO = -16'sd18688;
  localparam logic signed [15:0] VOL_HI = -16'sd256;
  // floor((5e + 768) / 1536) as (e * 5K + 768K) >> 27, K = ceil(2^27 / 1536)
  localparam logic [33:0] SCALE  = 34'd436910;
  localparam logic [33:0] OFFSET = 34'd67109376;

  logic signed [15:0] vol_s;
  logic        [14:0] span;
  logic        [33:0] scaled;

  assign vol_s = volume;

  // Clamp and shift to a zero-based span
  always_comb begin
    if (vol_s < VOL_LO) begin
      span = 15'd0;
    end else if (vol_s > VOL_HI) begin
      span = 15'd18432;
    end else begin
      span = 15'(vol_s - VOL_LO);
    end
  end

  // Rescale and round half up
  assign scaled = ({19'd0, span} * SCALE) + OFFSET;
  assign level  = (mute != 8'd0) ? 7'd0 : 7'd20 + scaled[33:27];

endmodule

`default_nettype wire

// File: rtl/uafu_ctrl.sv
// Request decode and unit state for the feature-unit responder.
`default_nettype none

module uafu_ctrl
  import uafu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire uafu_req_t  req,
  input  wire logic       vol_lock,
  input  wire logic [7:0] default_percent,
  output uafu_rsp_t       rsp
);

  logic [7:0]  speaker_mute, speaker_mute_next;
  logic [7:0]  mic_mute, mic_mute_next;
  logic [15:0] spk_volume, spk_volume_next;
  logic [15:0] mic_volume, mic_volume_next;
  logic        host_synced, host_synced_next;

  logic        spk;
  logic        known_unit;
  logic        push;
  logic [6:0]  amp;
  logic [6:0]  pct;
  logic [10:0] seed_m;
  logic [30:0] seed_prod;
  logic [15:0] seed_volume;

  assign spk        = (req.entity_id == ENT_SPK);
  assign known_unit = spk || (req.entity_id == ENT_MIC);

  // Seed volume: (-73 + 72 p / 100) dB, magnitude 256 (1825 - 18 p) / 25
  assign pct         = (default_percent > 8'd100) ? 7'd100 : default_percent[6:0];
  assign seed_m      = 11'd1825 - ({4'd0, pct} * 11'd18);
  assign seed_prod   = {20'd0, seed_m} * 31'd671089;
  assign seed_volume = 16'd0 - {1'b0, seed_prod[30:16]};

  // Decode the request and work out the state after it
  always_comb begin
    speaker_mute_next = speaker_mute;
    mic_mute_next     = mic_mute;
    spk_volume_next   = spk_volume;
    mic_volume_next   = mic_volume;
    host_synced_next  = host_synced;
    push              = 1'b0;
    rsp               = '0;

    unique case (req.opcode)
      OP_CLEAR: begin
        host_synced_next = 1'b0;
        rsp.accepted     = 1'b1;
      end
      OP_SET: begin
        if (known_unit && req.request_code == RQ_SET_CUR) begin
          if (req.control_selector == SEL_MUTE && req.request_length == 16'd1) begin
            if (spk) begin
              speaker_mute_next = req.payload[7:0];
              push              = 1'b1;
            end else begin
              mic_mute_next = req.payload[7:0];
            end
            rsp.accepted = 1'b1;
          end else if (req.control_selector == SEL_VOL &&
                       req.request_length == 16'd2) begin
            if (spk) begin
              spk_volume_next  = req.payload;
              host_synced_next = 1'b1;
              push             = 1'b1;
            end else begin
              mic_volume_next = req.payload;
            end
            rsp.accepted = 1'b1;
          end
        end
      end
      OP_GET: begin
        if (known_unit && req.control_selector == SEL_MUTE) begin
          rsp.accepted     = 1'b1;
          rsp.reply_length = 2'd1;
          rsp.reply_data   = {8'd0, spk ? speaker_mute : mic_mute};
        end else if (known_unit && req.control_selector == SEL_VOL) begin
          rsp.accepted     = 1'b1;
          rsp.reply_length = 2'd2;
          unique case (req.request_code)
            RQ_GET_CUR: begin
              if (spk && !host_synced) begin
                spk_volume_next  = seed_volume;
                host_synced_next = 1'b1;
                rsp.reply_data   = seed_volume;
              end else begin
                rsp.reply_data = spk ? spk_volume : mic_volume;
              end
            end
            RQ_GET_MIN: rsp.reply_data = spk ? SPK_VOL_MIN : MIC_VOL_MIN;
            RQ_GET_MAX: rsp.reply_data = spk ? SPK_VOL_MAX : MIC_VOL_MAX;
            RQ_GET_RES: rsp.reply_data = spk ? SPK_VOL_RES : MIC_VOL_RES;
            default: begin
              rsp.accepted     = 1'b0;
              rsp.reply_length = 2'd0;
            end
          endcase
        end
      end
      default: begin
        rsp = '0;
      end
    endcase

    // Issue an amp update unless locked
    if (push && !vol_lock) begin
      rsp.level_valid = 1'b1;
      rsp.amp_level   = amp;
    end
  end

  uafu_amp u_amp (
    .mute   (speaker_mute_next),
    .volume (spk_volume_next),
    .level  (amp)
  );

  // Commit state when the item leaves for the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      speaker_mute <= 8'd0;
      mic_mute     <= 8'd0;
      spk_volume   <= 16'd0;
      mic_volume   <= MIC_VOL_RESET;
      host_synced  <= 1'b0;
    end else if (fire) begin
      speaker_mute <= speaker_mute_next;
      mic_mute     <= mic_mute_next;
      spk_volume   <= spk_volume_next;
      mic_volume   <= mic_volume_next;
      host_synced  <= host_synced_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/usb_audio_feature_unit_volume_top.sv
// USB audio class 1 feature-unit responder: speaker and mic mute and volume.
//
// Requests come in on req (req_valid/req_ready), one decoded control
// transfer per item. Each request gives exactly one response on rsp
// (rsp_valid/rsp_ready): accepted flag, reply bytes for gets, and an amp
// level update for speaker mute or volume writes while volume lock is clear.
// Configuration writes (volume lock, default speaker percent) use
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// A request is captured into the input register, then decoded,
// committed to unit state and registered as the response.
// Throughput is one request per cycle while the receiver keeps up, set
// by the single decode stage between the input and response registers.
// When the receiver stalls the response holds, the input register still
// takes one more request, and req_ready drops once both are full.
// Reset (synchronous, active high) clears both registers, unmutes both
// units, sets speaker volume to 0, mic volume to 48 dB, clears the host
// sync flag, unlocks and sets the default percent to 100.
`default_nettype none

module usb_audio_feature_unit_volume_top
  import uafu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire uafu_req_t  req,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output uafu_rsp_t       rsp,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic       hold_valid;
  uafu_req_t  hold;
  logic       advance;
  uafu_rsp_t  result;
  logic       vol_lock;
  logic [7:0] default_percent;

  assign advance   = hold_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !hold_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vol_lock        <= 1'b0;
      default_percent <= DEFAULT_PERCENT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VOL_LOCK:        vol_lock        <= cfg_data[0];
        CFG_DEFAULT_PERCENT: default_percent <= cfg_data;
        default: begin
          vol_lock <= vol_lock;
        end
      endcase
    end
  end

  // Input register: capture a transfer, drop it when it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

  uafu_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .req             (hold),
    .vol_lock        (vol_lock),
    .default_percent (default_percent),
    .rsp             (result)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  a_level_needs_accept: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.level_valid || rsp.accepted))
    else $error("amp level issued on a refused request");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.level_valid |-> rsp.amp_level <= 7'd80)
    else $error("amp level out of range");

  a_refusal_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.accepted |->
      rsp.reply_length == 2'd0 && rsp.reply_data == 16'd0 && !rsp.level_valid)
    else $error("refused response carries data");

  a_lock_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && vol_lock |-> !result.level_valid)
    else $error("amp level issued while locked");

  a_capture: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> hold_valid)
    else $error("accepted request lost from input register");

endmodule

`default_nettype wire
